// ----- rtl/ihex_pkg.sv -----
// Shared constants, codes and the hex digit decoder for the Intel HEX record parser.
package ihex_pkg;

  // Record start character.
  localparam logic [7:0] START_CHAR = 8'h3A;

  // Characters allowed to pass while hunting before a missing start is reported.
  localparam logic [1:0] HUNT_WINDOW = 2'd3;

  // Parse phase codes; the unused codes behave as hunting.
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_TYPE = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CHK  = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  // Decoded hex digit: valid flag and nibble value.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // Decodes one ASCII character as a hex digit ('0'-'9', 'A'-'F', 'a'-'f').
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.valid = 1'b1;
    d.value = 4'hF;
    if (c > 8'd47 && c < 8'd58) begin
      d.value = c[3:0];
    end else if ((c > 8'd64 && c < 8'd71) || (c > 8'd96 && c < 8'd103)) begin
      d.value = c[3:0] + 4'd9;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

// ----- rtl/intel_hex_record_parser.sv -----
// Top level of the Intel HEX record parser: input register, decode logic and result register.

// The parser takes one ASCII character per request (or an end-of-input marker in
// in_tuser) and accepts a new request every clock cycle while the result side keeps up.
// When a character causes a result, the accepted character is held in the input register
// and its result goes to the result register. A result still waiting there holds back
// only a character that would cause another result. The rate is set by
// the single per-character state update between the input register and the result
// register. Results are data bytes as they complete, a record summary after the
// checksum (with the mod-256 sum check), or a status for a missing ':' within three
// characters or a record cut short by end of input. A non-hex character inside a
// record sets bad_digit and decodes as all ones. The load offset is taken big-endian.
module intel_hex_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [0:0]  in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [1:0] status_code, [9:2] data_value, [17:10] data_index,
                                  // [25:18] record_length, [41:26] record_address,
                                  // [49:42] record_type, [57:50] checksum_value,
                                  // [58] checksum_ok, [59] bad_digit, [63:60] zero
  output logic [1:0]  out_tuser   // [1:0] result_kind
);

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_eoi_r;

  // Parser state.
  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  hunt_r, hunt_nxt;
  logic [1:0]  digit_r, digit_nxt;
  logic [11:0] latch_r, latch_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        bad_r, bad_nxt;

  // Result register.
  logic        out_valid_r;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [59:0] out_data_r, out_data_nxt;

  // Per-character decode signals.
  ihex_pkg::hex_digit_t digit;
  logic        is_bad;
  logic [3:0]  nib;
  logic [7:0]  byte_v;
  logic [7:0]  sum_add;
  logic [7:0]  cnt_inc;
  logic [1:0]  hunt_inc;
  logic        emit;
  logic        out_free;
  logic        proceed;

  // Handshake: the held character moves on when its result, if any, has a slot.
  assign out_free   = !out_valid_r || out_tready;
  assign proceed    = in_valid_r && (!emit || out_free);
  assign in_tready  = !in_valid_r || proceed;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0, out_data_r};

  // Character decode shared by all phases.
  assign digit    = ihex_pkg::hex_decode(in_char_r);
  assign is_bad   = !digit.valid;
  assign nib      = digit.value;
  assign byte_v   = is_bad ? 8'hFF : {latch_r[3:0], nib};
  assign sum_add  = sum_r + byte_v;
  assign cnt_inc  = cnt_r + 8'd1;
  assign hunt_inc = hunt_r + 2'd1;

  // Next state and result for the held character.
  always_comb begin
    phase_nxt    = phase_r;
    hunt_nxt     = hunt_r;
    digit_nxt    = digit_r;
    latch_nxt    = latch_r;
    len_nxt      = len_r;
    addr_nxt     = addr_r;
    type_nxt     = type_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    bad_nxt      = bad_r;
    emit         = 1'b0;
    out_kind_nxt = ihex_pkg::KIND_STATUS;
    out_data_nxt = '0;

    unique case (phase_r)
      ihex_pkg::PH_LEN, ihex_pkg::PH_ADDR, ihex_pkg::PH_TYPE,
      ihex_pkg::PH_DATA, ihex_pkg::PH_CHK: begin
        if (in_eoi_r) begin
          // Record cut short: report what was decoded so far.
          emit         = 1'b1;
          out_kind_nxt = ihex_pkg::KIND_STATUS;
          out_data_nxt = {bad_r, 1'b0, 8'd0, type_r, addr_r, len_r, 8'd0, 8'd0,
                          ihex_pkg::ST_TRUNC};
          phase_nxt    = ihex_pkg::PH_HUNT;
          hunt_nxt     = 2'd0;
        end else begin
          bad_nxt = bad_r | is_bad;
          if (phase_r == ihex_pkg::PH_ADDR) begin
            // Four digits of the load offset, high byte first.
            case (digit_r)
              2'd0: latch_nxt = {8'd0, nib};
              2'd1: latch_nxt = is_bad ? 12'h0FF : {4'd0, latch_r[3:0], nib};
              2'd2: latch_nxt = {latch_r[7:0], nib};
              default: begin
                addr_nxt  = {latch_r[11:4], byte_v};
                sum_nxt   = sum_r + latch_r[11:4] + byte_v;
                phase_nxt = ihex_pkg::PH_TYPE;
              end
            endcase
            digit_nxt = digit_r + 2'd1;
          end else if (!digit_r[0]) begin
            // High digit of a byte.
            latch_nxt = {8'd0, nib};
            digit_nxt = 2'd1;
          end else begin
            // Low digit completes a byte.
            digit_nxt = 2'd0;
            case (phase_r)
              ihex_pkg::PH_LEN: begin
                len_nxt   = byte_v;
                sum_nxt   = byte_v;
                phase_nxt = ihex_pkg::PH_ADDR;
              end
              ihex_pkg::PH_TYPE: begin
                type_nxt  = byte_v;
                sum_nxt   = sum_add;
                cnt_nxt   = 8'd0;
                phase_nxt = (len_r == 8'd0) ? ihex_pkg::PH_CHK : ihex_pkg::PH_DATA;
              end
              ihex_pkg::PH_DATA: begin
                sum_nxt      = sum_add;
                emit         = 1'b1;
                out_kind_nxt = ihex_pkg::KIND_DATA;
                out_data_nxt = {bad_nxt, 1'b0, 8'd0, type_r, addr_r, len_r, cnt_r, byte_v,
                                ihex_pkg::ST_OK};
                cnt_nxt      = cnt_inc;
                if (cnt_inc >= len_r) begin
                  phase_nxt = ihex_pkg::PH_CHK;
                end
              end
              default: begin
                // Checksum byte closes the record.
                emit         = 1'b1;
                out_kind_nxt = ihex_pkg::KIND_RECORD;
                out_data_nxt = {bad_nxt, (sum_add == 8'd0), byte_v, type_r, addr_r, len_r,
                                8'd0, 8'd0, ihex_pkg::ST_OK};
                phase_nxt    = ihex_pkg::PH_HUNT;
                hunt_nxt     = 2'd0;
              end
            endcase
          end
        end
      end
      default: begin
        // Hunting for the record start.
        phase_nxt = ihex_pkg::PH_HUNT;
        if (in_eoi_r || in_char_r == ihex_pkg::START_CHAR ||
            hunt_inc >= ihex_pkg::HUNT_WINDOW) begin
          hunt_nxt  = 2'd0;
          digit_nxt = 2'd0;
          latch_nxt = '0;
          len_nxt   = '0;
          addr_nxt  = '0;
          type_nxt  = '0;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          bad_nxt   = 1'b0;
          if (!in_eoi_r && in_char_r == ihex_pkg::START_CHAR) begin
            phase_nxt = ihex_pkg::PH_LEN;
          end else begin
            emit         = 1'b1;
            out_kind_nxt = ihex_pkg::KIND_STATUS;
            out_data_nxt = {58'd0, ihex_pkg::ST_NO_START};
          end
        end else begin
          hunt_nxt = hunt_inc;
        end
      end
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_eoi_r  <= in_tuser[0];
    end
  end

  // Parser state advances once per processed character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ihex_pkg::PH_HUNT;
      hunt_r  <= '0;
      digit_r <= '0;
      latch_r <= '0;
      len_r   <= '0;
      addr_r  <= '0;
      type_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      bad_r   <= 1'b0;
    end else if (proceed) begin
      phase_r <= phase_nxt;
      hunt_r  <= hunt_nxt;
      digit_r <= digit_nxt;
      latch_r <= latch_nxt;
      len_r   <= len_nxt;
      addr_r  <= addr_nxt;
      type_r  <= type_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proceed && emit;
    end
    if (out_free && proceed && emit) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
    end
  end

endmodule
